@@ hw/rtl/positional_ordered_list_core_assert.svh @@
// ----------------------------------------------------------------------------
// positional_ordered_list_core_assert.svh
// Assertion macros for the positional ordered list core
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define POL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define POL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define POL_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define POL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/poslist_pkg.sv @@
// ----------------------------------------------------------------------------
// poslist_pkg
// Shared constants, operation codes and cell control type for the list core
// ----------------------------------------------------------------------------
package poslist_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 7;
   localparam int LEN_W    = 7;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // read gather tree
   localparam int GRP_SIZE = 8;
   localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   // operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // control broadcast to every cell
   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              read_en;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/positional_ordered_list_core.sv @@
// Sequence: a transaction is accepted in S_IDLE, passes the second level of the
//   read gather tree in S_GATHER and holds its response in S_RESP until rsp_ready;
//   a new transaction is accepted only once the response is taken.
// Insert and remove move the slots at and past the target position in the accept cycle.
// Reset empties the list (length zero); slot contents stay undefined until written.
// ----------------------------------------------------------------------------
// positional_ordered_list_core
// Bounded ordered list with positional insert, remove, read and clear
// ----------------------------------------------------------------------------
`include "positional_ordered_list_core_assert.svh"

module positional_ordered_list_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_operation,
   input  logic [poslist_pkg::POS_W-1:0]          req_position,
   input  logic signed [poslist_pkg::DATA_W-1:0]  req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_status,
   output logic signed [poslist_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [poslist_pkg::LEN_W-1:0]          rsp_length
);
   import poslist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_GATHER = 3'b010,
      S_RESP   = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              status_ff, status_in;
   logic [DATA_W-1:0] read_ff, read_in;
   logic [DATA_W-1:0] grp_ff [NUM_GRP];
   logic [DATA_W-1:0] grp_in [NUM_GRP];

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_hit  [CAPACITY];

   op_type            op;
   logic              accept;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic              ins_ok;
   logic              rem_ok;
   logic              rd_ok;
   cell_ctrl_type     ctrl;

   // request decode and range checks
   assign op      = op_type'(req_operation);
   assign req_ready = (state_ff == S_IDLE);
   assign accept  = req_valid && req_ready;
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign ins_ok  = (op == OP_INSERT) && (pos_ext <= cnt_ext) &&
                    (count_ff < CNT_W'(CAPACITY));
   assign rem_ok  = (op == OP_REMOVE) && (pos_ext < cnt_ext);
   assign rd_ok   = (op == OP_READ) && (pos_ext < cnt_ext);

   // control broadcast to the chain
   always_comb begin
      ctrl.shift_up   = accept && ins_ok;
      ctrl.shift_down = accept && rem_ok;
      ctrl.read_en    = accept && rd_ok;
      ctrl.pos        = pos_ext;
      ctrl.value      = DATA_W'(req_value);
   end

   // chain of list slots, each linked to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      poslist_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (CMP_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .hit_data   (cell_hit[i])
      );
   end

   // first gather level: or within each group of slots
   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_hit[g * GRP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   // second gather level
   always_comb begin
      read_in = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         read_in = read_in | grp_ff[g];
      end
   end

   // status and length update
   always_comb begin
      status_in = status_ff;
      count_in  = count_ff;
      if (accept) begin
         unique case (op)
            OP_INSERT: begin
               status_in = !ins_ok;
               if (ins_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               status_in = !rem_ok;
               if (rem_ok) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_READ: begin
               status_in = !rd_ok;
            end
            OP_CLEAR: begin
               status_in = 1'b0;
               count_in  = '0;
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end
   end

   // transaction sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_GATHER;
            end
         end
         S_GATHER: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         status_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // response data register
   always_ff @(posedge clock) begin
      if (state_ff == S_GATHER) begin
         read_ff <= read_in;
      end
   end

   // response outputs
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_status     = status_ff;
   assign rsp_read_value = read_ff;
   assign rsp_length     = LEN_W'(count_ff);

   // checks
   `POL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "length above capacity")
   `POL_ASSERT_SAME(a_one_side, clock, reset, 1'b1, !(req_ready && rsp_valid), "ready while response pending")
   `POL_ASSERT_NEXT(a_reject_hold, clock, reset, accept && status_in, count_ff == $past(count_ff), "rejected transaction changed length")
   `POL_ASSERT_NEXT(a_accept_seq, clock, reset, accept, state_ff == S_GATHER, "accept did not start gather")

endmodule

@@ hw/rtl/poslist_cell.sv @@
// ----------------------------------------------------------------------------
// poslist_cell
// One list slot: holds an entry, takes a neighbor's entry on a shift
// ----------------------------------------------------------------------------
module poslist_cell (
   input  logic                               clock,
   input  poslist_pkg::cell_ctrl_type         ctrl,
   input  logic [poslist_pkg::CMP_W-1:0]      cell_index,
   input  logic [poslist_pkg::DATA_W-1:0]     left_data,
   input  logic [poslist_pkg::DATA_W-1:0]     right_data,
   output logic [poslist_pkg::DATA_W-1:0]     data,
   output logic [poslist_pkg::DATA_W-1:0]     hit_data
);
   import poslist_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_pos;
   logic              past_pos;

   // where this slot sits relative to the target position
   assign at_pos   = (cell_index == ctrl.pos);
   assign past_pos = (cell_index > ctrl.pos);

   // insert opens a gap at the position, remove closes it
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (at_pos) begin
            data_in = ctrl.value;
         end else if (past_pos) begin
            data_in = left_data;
         end
      end else if (ctrl.shift_down) begin
         if (at_pos || past_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // entry data and read contribution to the gather tree
   assign data     = data_ff;
   assign hit_data = (ctrl.read_en && at_pos) ? data_ff : '0;

endmodule
